// File: sv/rdq_pkg.sv
// Shared constants, command and status codes for the reversible deque.
package rdq_pkg;

  localparam int DEPTH    = 1024;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int VALUE_W  = 32;
  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 2;

  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REVERSE    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// File: sv/rdq_if.sv
// Command and result channel interfaces for the reversible deque.
interface rdq_cmd_if import rdq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [VALUE_W-1:0]  push_value;

  modport source (output valid, opcode, push_value, input ready);
  modport sink   (input valid, opcode, push_value, output ready);
endinterface

interface rdq_res_if import rdq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  pop_value;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, pop_value, status, input ready);
  modport sink   (input valid, pop_value, status, output ready);
endinterface

// File: sv/reversible_deque.sv
// Double-ended queue over a ring RAM, with a constant-time reverse of its ends.
// Push and reverse complete on acceptance; the next word is then accepted unless a result word is stalled.
// Pop: the result word passes through the RAM read register, then the output register;
// empty-pop and full-push results reach the output register in the cycle after acceptance.
// A non-empty pop holds off the next command while the RAM read completes.
// Synchronous reset empties the queue and clears the reverse flag; RAM is not cleared.
module reversible_deque import rdq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rdq_cmd_if.sink    cmd,
  rdq_res_if.source  res
);

  logic [ADDR_W-1:0]         head, head_next;
  logic [CNT_W-1:0]          count, count_next;
  logic                      reversed, reversed_next;
  logic                      rd_pending;
  logic                      res_valid;
  logic signed [VALUE_W-1:0] res_value;
  logic [STATUS_W-1:0]       res_status;

  logic                      accept;
  logic                      is_pop, is_push, at_high;
  logic                      empty, full;
  logic [SUM_W-1:0]          end_raw;
  logic [ADDR_W-1:0]         end_slot, head_dec, head_inc;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;

  assign cmd.ready = !rd_pending && (!res_valid || res.ready);
  assign accept    = cmd.valid && cmd.ready;

  assign is_pop  = (cmd.opcode == OP_POP_BACK) || (cmd.opcode == OP_POP_FRONT);
  assign is_push = (cmd.opcode == OP_PUSH_BACK) || (cmd.opcode == OP_PUSH_FRONT);
  // back is the physical high end unless reversed
  assign at_high = ((cmd.opcode == OP_POP_BACK) || (cmd.opcode == OP_PUSH_BACK)) ^ reversed;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));

  // slot after the last word for a push, the last word itself for a pop
  assign end_raw  = SUM_W'(head) + SUM_W'(count) - SUM_W'(is_pop);
  assign end_slot = (end_raw >= SUM_W'(DEPTH)) ? ADDR_W'(end_raw - SUM_W'(DEPTH))
                                               : ADDR_W'(end_raw);
  assign head_dec = (head == '0) ? ADDR_W'(DEPTH - 1) : head - 1'b1;
  assign head_inc = (head == ADDR_W'(DEPTH - 1)) ? '0 : head + 1'b1;

  assign ram_we    = accept && is_push && !full;
  assign ram_waddr = at_high ? end_slot : head_dec;
  assign ram_raddr = at_high ? end_slot : head;

  rdq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.push_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    head_next     = head;
    count_next    = count;
    reversed_next = reversed;
    if (accept) begin
      if (cmd.opcode == OP_REVERSE) begin
        reversed_next = !reversed;
      end else if (is_pop && !empty) begin
        count_next = count - 1'b1;
        if (!at_high) begin
          head_next = head_inc;
        end
      end else if (is_push && !full) begin
        count_next = count + 1'b1;
        if (!at_high) begin
          head_next = head_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      reversed   <= 1'b0;
      rd_pending <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      head       <= head_next;
      count      <= count_next;
      reversed   <= reversed_next;
      rd_pending <= accept && is_pop && !empty;
      if (rd_pending) begin
        res_valid  <= 1'b1;
        res_value  <= ram_rdata;
        res_status <= ST_OK;
      end else if (accept && is_pop && empty) begin
        res_valid  <= 1'b1;
        res_value  <= '0;
        res_status <= ST_EMPTY;
      end else if (accept && is_push && full) begin
        res_valid  <= 1'b1;
        res_value  <= '0;
        res_status <= ST_FULL;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign res.valid     = res_valid;
  assign res.pop_value = res_value;
  assign res.status    = res_status;

endmodule

// File: sv/rdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/rdq_checker.sv
// Port-level checks for the reversible deque, bound to the top level.
module rdq_checker import rdq_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      cmd_valid,
  input logic                      cmd_ready,
  input logic [OPCODE_W-1:0]       cmd_opcode,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic signed [VALUE_W-1:0] res_pop_value,
  input logic [STATUS_W-1:0]       res_status
);

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result word valid after reset");

  // a stalled result word must block new commands
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !cmd_ready)
    else $error("command accepted while result stalled");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status != ST_OK) |-> (res_pop_value == '0))
    else $error("non-zero value on error result");

  // reverse gives no result word
  a_rev_silent: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd_opcode == OP_REVERSE) |=> !res_valid)
    else $error("result word after reverse");

  // stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(res_pop_value) && $stable(res_status)))
    else $error("stalled result word changed");

endmodule

bind reversible_deque rdq_checker u_rdq_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .cmd_opcode    (cmd.opcode),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_pop_value (res.pop_value),
  .res_status    (res.status)
);
